FILE: rtl/drld_pkg.sv
package drld_pkg;

  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int POS_W     = 3;
  localparam int CLUSTER_W = 64;
  localparam int COUNT_W   = 32;
  localparam int ERR_W     = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [NIB_W-1:0] MAX_LEN = 4'd8;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_COUNT  = 3'b010,
    PH_OFFSET = 3'b100
  } phase_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_HDR = 2'd1,
    ERR_BAD_LEN  = 2'd2
  } err_t;

  localparam logic [ADDR_W-3:0] REG_CLUSTERS_NEEDED = 1'b0;

endpackage

FILE: rtl/data_run_list_decoder_unit.sv
// Run list decoder: turns a byte stream of run headers, counts and offsets
// into one result per complete run.
// Input channel (in_*): one run list byte per request, in_tuser marks the
// first byte of a new list and clears all running state before that byte.
// Output channel (out_*): tdata carries start cluster, clusters taken and map
// index; tlast flags the run that completes the map; tuser holds the error
// code (zero header before done, length nibble above eight).
// Config port (cfg_*): APB-style, clusters_needed at byte address 0. Write it
// only while no request is in flight.
// A result passes the input register, then the result register, after its
// last byte is accepted. Throughput: one byte per cycle while the receiver
// takes results, set by the single pass from the input register through the
// 64-bit cluster add into the result register.
// Reset clears the run state, the map count and clusters_needed; both
// channels come up empty. When the receiver stalls, the result register
// holds, the input register fills and in_tready drops; nothing is lost.
// Once the map is complete, header bytes are consumed without a result.
module data_run_list_decoder_unit
  import drld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] run_byte
  input  logic                   in_tuser,   // [0] list_start
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [63:0] run_start_cluster, [95:64] run_clusters, [127:96] map_index
  output logic [CLUSTER_W+2*COUNT_W-1:0] out_tdata,
  output logic                   out_tlast,  // final_run
  output logic [ERR_W-1:0]       out_tuser,  // [1:0] error_code
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [ADDR_W-1:0]      cfg_paddr,
  input  logic [DATA_W-1:0]      cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  // configuration
  logic [COUNT_W-1:0] needed_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[ADDR_W-1:2] == REG_CLUSTERS_NEEDED) ? needed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[ADDR_W-1:2] == REG_CLUSTERS_NEEDED) begin
      needed_r <= cfg_pwdata;
    end
  end

  // input register
  logic              in_valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              start_r;
  logic              advance;
  logic              proc;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign proc      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
  end

  // run state
  phase_t               phase_r, phase_nxt;
  logic [NIB_W-1:0]     cnt_left_r, cnt_left_nxt;
  logic [NIB_W-1:0]     off_left_r, off_left_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [CLUSTER_W-1:0] cacc_r, cacc_nxt;
  logic [CLUSTER_W-1:0] oacc_r, oacc_nxt;
  logic [CLUSTER_W-1:0] running_r, running_nxt;
  logic [COUNT_W-1:0]   mapped_r, mapped_nxt;

  // state as seen after an optional list start clear
  phase_t               cur_phase;
  logic [NIB_W-1:0]     cur_cnt_left, cur_off_left;
  logic [POS_W-1:0]     cur_pos;
  logic [CLUSTER_W-1:0] cur_cacc, cur_oacc, cur_running;
  logic [COUNT_W-1:0]   cur_mapped;

  logic [NIB_W-1:0]     cl, ol;
  logic [CLUSTER_W-1:0] shifted;
  logic [CLUSTER_W-1:0] sign_fill;
  logic [CLUSTER_W-1:0] fin_oacc;
  logic [NIB_W-1:0]     cnt_dec, off_dec;
  logic                 fin;
  logic                 err_en;
  err_t                 err_code;

  logic [CLUSTER_W-1:0] fin_running;
  logic [COUNT_W-1:0]   remaining, take, fin_mapped;

  assign cur_phase    = start_r ? PH_HEADER : phase_r;
  assign cur_cnt_left = start_r ? '0 : cnt_left_r;
  assign cur_off_left = start_r ? '0 : off_left_r;
  assign cur_pos      = start_r ? '0 : pos_r;
  assign cur_cacc     = start_r ? '0 : cacc_r;
  assign cur_oacc     = start_r ? '0 : oacc_r;
  assign cur_running  = start_r ? '0 : running_r;
  assign cur_mapped   = start_r ? '0 : mapped_r;

  assign cl        = byte_r[NIB_W-1:0];
  assign ol        = byte_r[BYTE_W-1:NIB_W];
  assign shifted   = {{(CLUSTER_W-BYTE_W){1'b0}}, byte_r} << {cur_pos, 3'b000};
  // sign fill above the top offset byte; no fill when it is the eighth byte
  assign sign_fill = (byte_r[BYTE_W-1] && cur_pos != {POS_W{1'b1}}) ?
                     ({CLUSTER_W{1'b1}} << ({1'b0, cur_pos, 3'b000} + 7'd8)) : '0;
  assign cnt_dec   = cur_cnt_left - 4'd1;
  assign off_dec   = cur_off_left - 4'd1;

  always_comb begin
    phase_nxt    = cur_phase;
    cnt_left_nxt = cur_cnt_left;
    off_left_nxt = cur_off_left;
    pos_nxt      = cur_pos;
    cacc_nxt     = cur_cacc;
    oacc_nxt     = cur_oacc;
    fin          = 1'b0;
    fin_oacc     = cur_oacc;
    err_en       = 1'b0;
    err_code     = ERR_NONE;
    case (cur_phase)
      PH_HEADER: begin
        if (cur_mapped < needed_r) begin
          if (byte_r == '0) begin
            err_en   = 1'b1;
            err_code = ERR_ZERO_HDR;
          end else if (cl > MAX_LEN || ol > MAX_LEN) begin
            err_en   = 1'b1;
            err_code = ERR_BAD_LEN;
          end else begin
            cnt_left_nxt = cl;
            off_left_nxt = ol;
            pos_nxt      = '0;
            cacc_nxt     = '0;
            oacc_nxt     = '0;
            phase_nxt    = (cl != '0) ? PH_COUNT : PH_OFFSET;
          end
        end
      end
      PH_COUNT: begin
        cacc_nxt     = cur_cacc | shifted;
        pos_nxt      = cur_pos + 3'd1;
        cnt_left_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          pos_nxt = '0;
          if (cur_off_left == '0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        if (cur_off_left == '0) begin
          fin = 1'b1;
        end else begin
          oacc_nxt     = cur_oacc | shifted;
          pos_nxt      = cur_pos + 3'd1;
          off_left_nxt = off_dec;
          if (off_dec == '0) begin
            fin_oacc = cur_oacc | shifted | sign_fill;
            fin      = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // run completion: advance the cluster number and clip to the remaining need
  assign fin_running = cur_running + fin_oacc;
  assign remaining   = (needed_r > cur_mapped) ? (needed_r - cur_mapped) : '0;
  assign take        = (cacc_nxt < {{(CLUSTER_W-COUNT_W){1'b0}}, remaining}) ?
                       cacc_nxt[COUNT_W-1:0] : remaining;
  assign fin_mapped  = cur_mapped + take;
  assign running_nxt = fin ? fin_running : cur_running;
  assign mapped_nxt  = fin ? fin_mapped : cur_mapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_left_r <= '0;
      off_left_r <= '0;
      pos_r      <= '0;
      cacc_r     <= '0;
      oacc_r     <= '0;
      running_r  <= '0;
      mapped_r   <= '0;
    end else if (proc) begin
      // a finished run clears the per-run state
      phase_r    <= fin ? PH_HEADER : phase_nxt;
      cnt_left_r <= fin ? '0 : cnt_left_nxt;
      off_left_r <= fin ? '0 : off_left_nxt;
      pos_r      <= fin ? '0 : pos_nxt;
      cacc_r     <= fin ? '0 : cacc_nxt;
      oacc_r     <= fin ? '0 : oacc_nxt;
      running_r  <= running_nxt;
      mapped_r   <= mapped_nxt;
    end
  end

  // result register
  logic                 out_valid_r;
  logic [CLUSTER_W-1:0] res_start_r;
  logic [COUNT_W-1:0]   res_clusters_r, res_index_r;
  logic                 res_final_r;
  logic [ERR_W-1:0]     res_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && (fin || err_en);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      if (fin) begin
        res_start_r    <= fin_running;
        res_clusters_r <= take;
        res_index_r    <= cur_mapped;
        res_final_r    <= (fin_mapped >= needed_r);
        res_err_r      <= ERR_NONE;
      end else begin
        res_start_r    <= '0;
        res_clusters_r <= '0;
        res_index_r    <= '0;
        res_final_r    <= 1'b0;
        res_err_r      <= err_code;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_index_r, res_clusters_r, res_start_r};
  assign out_tlast  = res_final_r;
  assign out_tuser  = res_err_r;

endmodule
